/* hw/rtl/mvsf_pkg.sv */
// Package for the memory value search filter: table sizing, entry layout,
// register indexes and the codes used by the filter and its checker.
// No dependencies.
package mvsf_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int ENTRY_AW    = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int SURV_W      = 17;

   // register indexes on the csr port
   localparam logic [2:0] REG_PASS_KIND      = 3'd0;
   localparam logic [2:0] REG_VALUE_TYPE     = 3'd1;
   localparam logic [2:0] REG_COMPARE_MODE   = 3'd2;
   localparam logic [2:0] REG_HEURISTIC      = 3'd3;
   localparam logic [2:0] REG_TARGET_VALUE   = 3'd4;
   localparam logic [2:0] REG_TARGET_PRESENT = 3'd5;

   localparam logic [1:0] PASS_BY_VALUE = 2'd0;
   localparam logic [1:0] PASS_UNKNOWN  = 2'd1;
   localparam logic [1:0] PASS_REFINE   = 2'd2;

   localparam logic [2:0] TYPE_U8  = 3'd0;
   localparam logic [2:0] TYPE_U16 = 3'd2;
   localparam logic [2:0] TYPE_S32 = 3'd5;

   localparam logic [2:0] CMP_CHANGED   = 3'd0;
   localparam logic [2:0] CMP_UNCHANGED = 3'd1;
   localparam logic [2:0] CMP_INCREASED = 3'd2;
   localparam logic [2:0] CMP_DECREASED = 3'd3;
   localparam logic [2:0] CMP_EQUAL     = 3'd4;
   localparam logic [2:0] CMP_NOT_EQUAL = 3'd5;

   localparam logic [1:0] HEUR_EXACT = 2'd0;
   localparam logic [1:0] HEUR_BOOL  = 2'd1;
   localparam logic [1:0] HEUR_TOL1  = 2'd2;
   localparam logic [1:0] HEUR_TOL2  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FAIL     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [2:0]  region;
      logic [31:0] address;
      logic [31:0] value;
   } entry_type;

endpackage

/* hw/rtl/memory_value_search_filter.sv */
// A word accepted into the compare stage (s1_) shows its result (if any) on the rsp_ ports
// from the result registers, for exactly one cycle (rsp_strobe).
// Throughput: one word per cycle; busy stays low. The table memory is read one
// entry ahead of the compare stage, and the survivor is written back behind it.
// Reset clears counters, session and registers; the table itself is not cleared.
// Depends on mvsf_pkg.
module memory_value_search_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic [31:0]                 req_address,
   input  logic [2:0]                  req_region,
   input  logic [31:0]                 req_raw_value,
   input  logic                        req_read_ok,
   output logic                        rsp_strobe,
   output logic                        rsp_is_summary,
   output logic [31:0]                 rsp_address_res,
   output logic [2:0]                  rsp_region_res,
   output logic [31:0]                 rsp_previous_value,
   output logic [31:0]                 rsp_current_value,
   output logic [1:0]                  rsp_status,
   output logic [mvsf_pkg::SURV_W-1:0] rsp_survivor_count,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [31:0]                 csr_wdata
);
   import mvsf_pkg::*;

   function automatic logic [31:0] type_mask(input logic [2:0] t);
      logic [31:0] m;
      unique case (t[2:1])
         2'd0:    m = 32'h0000_00FF;
         2'd1:    m = 32'h0000_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic signed [32:0] type_value(input logic [31:0] raw,
                                                     input logic [2:0]  t);
      logic [31:0]        v;
      logic               sg;
      logic signed [32:0] r;
      v  = raw & type_mask(t);
      sg = t[0] && (t <= TYPE_S32);
      unique case (t[2:1])
         2'd0:    r = {{25{sg & v[7]}}, v[7:0]};
         2'd1:    r = {{17{sg & v[15]}}, v[15:0]};
         default: r = {sg & v[31], v};
      endcase
      return r;
   endfunction

   function automatic logic target_match(input logic signed [32:0] cur,
                                         input logic signed [32:0] tgt,
                                         input logic [1:0]         heur);
      logic signed [33:0] d;
      logic               hit;
      d = {cur[32], cur} - {tgt[32], tgt};
      unique case (heur)
         HEUR_BOOL: begin
            if (tgt == 33'sd0 || tgt == 33'sd1)
               hit = (cur == 33'sd0) || (cur == 33'sd1);
            else if (tgt == 33'sd2 || tgt == 33'sd3)
               hit = (d == -34'sd1) || (d == 34'sd0);
            else
               hit = (d == 34'sd0);
         end
         HEUR_TOL1: hit = (d >= -34'sd1) && (d <= 34'sd1);
         HEUR_TOL2: hit = (d >= -34'sd2) && (d <= 34'sd2);
         default:   hit = (d == 34'sd0);
      endcase
      return hit;
   endfunction

   // configuration registers
   logic [1:0]  pass_kind_ff;
   logic [2:0]  value_type_ff;
   logic [2:0]  compare_mode_ff;
   logic [1:0]  heuristic_ff;
   logic [31:0] target_value_ff;
   logic        target_present_ff;

   // pass and session state
   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [COUNT_W-1:0] read_index_ff, read_index_in;
   logic [COUNT_W-1:0] write_index_ff, write_index_in;
   logic               session_active_ff, session_active_in;
   logic [2:0]         latched_type_ff, latched_type_in;
   logic               seen_ff, seen_in;
   logic               failed_ff, failed_in;
   logic               overflow_ff, overflow_in;

   // compare stage
   logic        s1_valid_ff;
   logic        s1_kind_ff;
   logic [31:0] s1_address_ff;
   logic [2:0]  s1_region_ff;
   logic [31:0] s1_raw_ff;
   logic        s1_ok_ff;

   // table
   entry_type entry_mem [TABLE_DEPTH];
   entry_type rd_entry_ff;
   entry_type mem_wdata;
   logic      mem_we;

   // result word
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_is_summary_ff, rsp_is_summary_in;
   logic [31:0]         rsp_address_ff, rsp_address_in;
   logic [2:0]          rsp_region_ff, rsp_region_in;
   logic [31:0]         rsp_previous_ff, rsp_previous_in;
   logic [31:0]         rsp_current_ff, rsp_current_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic               accept;
   logic [2:0]         t_sel;
   logic [31:0]        v_masked;
   logic signed [32:0] cur_val;
   logic signed [32:0] prev_val;
   logic signed [32:0] tgt_val;
   logic               match;
   logic               refine_ok;
   logic               aligned;
   logic               start_fail;
   logic [COUNT_W-1:0] write_next;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_kind_ff      <= PASS_REFINE;
         value_type_ff     <= TYPE_U16;
         compare_mode_ff   <= CMP_CHANGED;
         heuristic_ff      <= HEUR_EXACT;
         target_value_ff   <= 32'd0;
         target_present_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PASS_KIND:      pass_kind_ff      <= csr_wdata[1:0];
            REG_VALUE_TYPE:     value_type_ff     <= csr_wdata[2:0];
            REG_COMPARE_MODE:   compare_mode_ff   <= csr_wdata[2:0];
            REG_HEURISTIC:      heuristic_ff      <= csr_wdata[1:0];
            REG_TARGET_VALUE:   target_value_ff   <= csr_wdata;
            REG_TARGET_PRESENT: target_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_kind_ff    <= req_kind;
         s1_address_ff <= req_address;
         s1_region_ff  <= req_region;
         s1_raw_ff     <= req_raw_value;
         s1_ok_ff      <= req_read_ok;
      end
   end

   // Read runs one entry ahead: the address is the read index the compare
   // stage leaves behind. Writes land at or below the old read index, so
   // they never hit the entry being fetched.
   always_ff @(posedge clock) begin
      rd_entry_ff <= entry_mem[read_index_in[ENTRY_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[write_index_ff[ENTRY_AW-1:0]] <= mem_wdata;
      end
   end

   always_comb begin
      t_sel      = (pass_kind_ff == PASS_REFINE) ? latched_type_ff : value_type_ff;
      v_masked   = s1_raw_ff & type_mask(t_sel);
      cur_val    = type_value(s1_raw_ff, t_sel);
      prev_val   = type_value(rd_entry_ff.value, t_sel);
      tgt_val    = {target_value_ff[31], target_value_ff};
      match      = target_match(cur_val, tgt_val, heuristic_ff);
      write_next = write_index_ff + COUNT_W'(1);

      unique case (compare_mode_ff)
         CMP_CHANGED:   refine_ok = (cur_val != prev_val);
         CMP_UNCHANGED: refine_ok = (cur_val == prev_val);
         CMP_INCREASED: refine_ok = (cur_val > prev_val);
         CMP_DECREASED: refine_ok = (cur_val < prev_val);
         CMP_EQUAL:     refine_ok = target_present_ff & match;
         CMP_NOT_EQUAL: refine_ok = target_present_ff & ~match;
         default:       refine_ok = 1'b0;
      endcase

      // 8-bit types take any address, wider ones need it even, codes 6 and 7 none
      if (value_type_ff[2:1] == TYPE_U8[2:1])
         aligned = 1'b1;
      else if (value_type_ff <= TYPE_S32)
         aligned = ~s1_address_ff[0];
      else
         aligned = 1'b0;

      start_fail = ~seen_ff | ((pass_kind_ff == PASS_UNKNOWN) & failed_ff);

      entry_count_in    = entry_count_ff;
      read_index_in     = read_index_ff;
      write_index_in    = write_index_ff;
      session_active_in = session_active_ff;
      latched_type_in   = latched_type_ff;
      seen_in           = seen_ff;
      failed_in         = failed_ff;
      overflow_in       = overflow_ff;

      mem_we            = 1'b0;
      mem_wdata.region  = s1_region_ff;
      mem_wdata.address = s1_address_ff;
      mem_wdata.value   = v_masked;

      rsp_strobe_in     = 1'b0;
      rsp_is_summary_in = 1'b0;
      rsp_address_in    = 32'd0;
      rsp_region_in     = 3'd0;
      rsp_previous_in   = 32'd0;
      rsp_current_in    = 32'd0;
      rsp_status_in     = STATUS_OK;
      rsp_count_in      = write_next;

      if (s1_valid_ff && s1_kind_ff) begin
         // end of pass
         rsp_strobe_in     = 1'b1;
         rsp_is_summary_in = 1'b1;
         if (pass_kind_ff == PASS_BY_VALUE || pass_kind_ff == PASS_UNKNOWN) begin
            if (start_fail) begin
               session_active_in = 1'b0;
               entry_count_in    = '0;
               latched_type_in   = TYPE_U16;
               rsp_status_in     = STATUS_FAIL;
            end else begin
               session_active_in = 1'b1;
               latched_type_in   = value_type_ff;
               entry_count_in    = write_index_ff;
               rsp_status_in     = overflow_ff ? STATUS_OVERFLOW : STATUS_OK;
            end
         end else if (pass_kind_ff == PASS_REFINE && session_active_ff) begin
            entry_count_in = write_index_ff;
         end else begin
            rsp_status_in = STATUS_FAIL;
         end
         rsp_count_in   = entry_count_in;
         read_index_in  = '0;
         write_index_in = '0;
         seen_in        = 1'b0;
         failed_in      = 1'b0;
         overflow_in    = 1'b0;
      end else if (s1_valid_ff) begin
         if (pass_kind_ff == PASS_BY_VALUE || pass_kind_ff == PASS_UNKNOWN) begin
            if (aligned) begin
               seen_in = 1'b1;
               if (!s1_ok_ff) begin
                  failed_in = 1'b1;
               end else if (pass_kind_ff == PASS_UNKNOWN || match) begin
                  if (write_index_ff >= COUNT_W'(TABLE_DEPTH)) begin
                     overflow_in = 1'b1;
                  end else begin
                     mem_we          = 1'b1;
                     write_index_in  = write_next;
                     rsp_strobe_in   = 1'b1;
                     rsp_address_in  = s1_address_ff;
                     rsp_region_in   = s1_region_ff;
                     rsp_previous_in = v_masked;
                     rsp_current_in  = v_masked;
                  end
               end
            end
         end else if (pass_kind_ff == PASS_REFINE && session_active_ff &&
                      read_index_ff < entry_count_ff &&
                      read_index_ff < COUNT_W'(TABLE_DEPTH)) begin
            read_index_in = read_index_ff + COUNT_W'(1);
            if (s1_ok_ff && refine_ok) begin
               mem_we            = 1'b1;
               mem_wdata.region  = rd_entry_ff.region;
               mem_wdata.address = rd_entry_ff.address;
               write_index_in    = write_next;
               rsp_strobe_in     = 1'b1;
               rsp_address_in    = rd_entry_ff.address;
               rsp_region_in     = rd_entry_ff.region;
               rsp_previous_in   = rd_entry_ff.value;
               rsp_current_in    = v_masked;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff    <= '0;
         read_index_ff     <= '0;
         write_index_ff    <= '0;
         session_active_ff <= 1'b0;
         latched_type_ff   <= TYPE_U16;
         seen_ff           <= 1'b0;
         failed_ff         <= 1'b0;
         overflow_ff       <= 1'b0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         entry_count_ff    <= entry_count_in;
         read_index_ff     <= read_index_in;
         write_index_ff    <= write_index_in;
         session_active_ff <= session_active_in;
         latched_type_ff   <= latched_type_in;
         seen_ff           <= seen_in;
         failed_ff         <= failed_in;
         overflow_ff       <= overflow_in;
         rsp_strobe_ff     <= rsp_strobe_in;
      end
      rsp_is_summary_ff <= rsp_is_summary_in;
      rsp_address_ff    <= rsp_address_in;
      rsp_region_ff     <= rsp_region_in;
      rsp_previous_ff   <= rsp_previous_in;
      rsp_current_ff    <= rsp_current_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_is_summary     = rsp_is_summary_ff;
   assign rsp_address_res    = rsp_address_ff;
   assign rsp_region_res     = rsp_region_ff;
   assign rsp_previous_value = rsp_previous_ff;
   assign rsp_current_value  = rsp_current_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_survivor_count = SURV_W'(rsp_count_ff);

endmodule

/* hw/rtl/mvsf_checker.sv */
// Port-level checks for the memory value search filter, bound to the top level.
// Depends on mvsf_pkg and memory_value_search_filter.
module mvsf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic                        rsp_is_summary,
   input logic [31:0]                 rsp_address_res,
   input logic [2:0]                  rsp_region_res,
   input logic [31:0]                 rsp_previous_value,
   input logic [31:0]                 rsp_current_value,
   input logic [1:0]                  rsp_status,
   input logic [mvsf_pkg::SURV_W-1:0] rsp_survivor_count
);
   import mvsf_pkg::*;

   // every result word traces back to a word accepted by the filter
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result word without an accepted request");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_summary |->
         rsp_address_res == 32'd0 && rsp_region_res == 3'd0 &&
         rsp_previous_value == 32'd0 && rsp_current_value == 32'd0)
      else $error("summary word carries candidate fields");

   // a report is written before it is counted, so its count is at least one
   a_report_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_summary |->
         rsp_status == STATUS_OK && rsp_survivor_count != '0)
      else $error("candidate report with bad status or zero count");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_summary && rsp_status == STATUS_OVERFLOW |->
         rsp_survivor_count == SURV_W'(TABLE_DEPTH))
      else $error("overflow summary with table not full");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_summary |->
         rsp_status == STATUS_OK || rsp_status == STATUS_FAIL ||
         rsp_status == STATUS_OVERFLOW)
      else $error("summary status code out of range");

endmodule

bind memory_value_search_filter mvsf_checker u_mvsf_checker (.*);
